### rtl/core/gthd_pkg.sv
package gthd_pkg;

    localparam int StateCountDef = 64;
    localparam int MaxOutBits    = 8;
    localparam int SymW          = 8;
    localparam int SymCap        = (MaxOutBits < SymW) ? MaxOutBits : SymW;
    localparam int LenW          = 4;
    localparam int DistW         = 4;
    localparam int EntStateW     = 6;
    localparam int InDataW       = 24;
    localparam int OutDataW      = 8;

    localparam logic [LenW-1:0] BpsReset = LenW'(2);

    typedef enum logic [1:0] {
        MODE_BIT     = 2'd0,
        MODE_LOAD    = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef struct packed {
        logic              decided;
        logic [DistW-1:0]  distance;
    } pick_t;

    function automatic logic [DistW-1:0] ones8(input logic [SymW-1:0] v);
        logic [DistW-1:0] c;
        c = '0;
        for (int i = 0; i < SymW; i++) begin
            c = c + DistW'(v[i]);
        end
        return c;
    endfunction

endpackage

### rtl/core/gthd_ram.sv
module gthd_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/gthd_branch_pick.sv
module gthd_branch_pick
    import gthd_pkg::*;
(
    input  logic [SymW-1:0] word,
    input  logic [LenW-1:0] len,
    input  logic [SymW-1:0] sym0,
    input  logic [SymW-1:0] sym1,
    output pick_t           pick
);

    logic [SymW-1:0]  mask;
    logic [DistW-1:0] d0;
    logic [DistW-1:0] d1;

    always_comb
    begin
        mask = SymW'((9'd1 << len) - 9'd1);
        d0   = ones8((word ^ sym0) & mask);
        d1   = ones8((word ^ sym1) & mask);
        if (d0 <= d1)
        begin
            pick.decided  = 1'b0;
            pick.distance = d0;
        end
        else
        begin
            pick.decided  = 1'b1;
            pick.distance = d1;
        end
    end

endmodule

### rtl/core/greedy_trellis_hard_decoder_core.sv
// output: the item completing a word registers its result in the output or skid register
// throughput: one item per cycle while the skid register is empty; after each table load,
// input waits while the table memory read port refreshes the entries of the current state
// reset (rst_n low, asynchronous): state, bit position and word cleared, symbol length 2,
// output buffer emptied; table contents stay undefined until loaded
module greedy_trellis_hard_decoder_core
    import gthd_pkg::*;
#(
    parameter int STATE_COUNT = StateCountDef
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // rx_bit, entry_state, entry_input, entry_next, entry_output, zero pad
    input  logic [InDataW-1:0]  s_axis_tdata,
    // mode
    input  logic [1:0]          s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // decided_bit, branch_distance, zero pad
    output logic [OutDataW-1:0] m_axis_tdata,
    input  logic                cfg_we,
    input  logic [LenW-1:0]     cfg_wdata
);

    localparam int StW  = $clog2(STATE_COUNT);
    localparam int EntW = StW + SymW;

    logic [StW-1:0]  mod_tab [64];

    for (genvar i = 0; i < 64; i++)
    begin : g_mod
        assign mod_tab[i] = StW'(i % STATE_COUNT);
    end

    logic [LenW-1:0]       bps_reg;
    logic [StW-1:0]        state_reg, state_next;
    logic [2:0]            pos_reg, pos_next;
    logic [SymW-1:0]       word_reg, word_next;
    logic                  stale_reg, stale_next;
    logic                  m_valid_reg, sk_valid_reg;
    logic [OutDataW-1:0]   m_data_reg, sk_data_reg;

    mode_t                 mode;
    logic                  rx_bit;
    logic [EntStateW-1:0]  entry_state;
    logic                  entry_input;
    logic [EntStateW-1:0]  entry_next;
    logic [SymW-1:0]       entry_output;

    logic                  accept;
    logic                  in_range;
    logic                  we0, we1;
    logic [StW-1:0]        waddr;
    logic [EntW-1:0]       wdata;
    logic [EntW-1:0]       rd0, rd1;
    logic [LenW-1:0]       len;
    logic [SymW-1:0]       word_shift;
    logic                  complete;
    logic                  push;
    logic                  pop;
    pick_t                 pick;
    logic [OutDataW-1:0]   result;

    assign mode         = mode_t'(s_axis_tuser);
    assign rx_bit       = s_axis_tdata[0];
    assign entry_state  = s_axis_tdata[6:1];
    assign entry_input  = s_axis_tdata[7];
    assign entry_next   = s_axis_tdata[13:8];
    assign entry_output = s_axis_tdata[21:14];

    assign s_axis_tready = !stale_reg && !sk_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // table write
    assign in_range = 9'(entry_state) < 9'(STATE_COUNT);
    assign waddr    = StW'(entry_state);
    assign wdata    = {mod_tab[entry_next], entry_output};
    assign we0      = accept && (mode == MODE_LOAD) && in_range && !entry_input;
    assign we1      = accept && (mode == MODE_LOAD) && in_range && entry_input;

    gthd_ram #(.WIDTH(EntW), .DEPTH(STATE_COUNT)) u_ram0 (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (state_next),
        .rdata (rd0)
    );

    gthd_ram #(.WIDTH(EntW), .DEPTH(STATE_COUNT)) u_ram1 (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (state_next),
        .rdata (rd1)
    );

    // effective symbol length
    always_comb
    begin
        if (bps_reg == '0)
        begin
            len = LenW'(1);
        end
        else if (bps_reg > LenW'(SymCap))
        begin
            len = LenW'(SymCap);
        end
        else
        begin
            len = bps_reg;
        end
    end

    assign word_shift = {word_reg[SymW-2:0], rx_bit};
    assign complete   = (LenW'(pos_reg) + LenW'(1)) >= len;

    gthd_branch_pick u_pick (
        .word (word_shift),
        .len  (len),
        .sym0 (rd0[SymW-1:0]),
        .sym1 (rd1[SymW-1:0]),
        .pick (pick)
    );

    assign result = {{(OutDataW - 1 - DistW){1'b0}}, pick.distance, pick.decided};

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        word_next  = word_reg;
        push       = 1'b0;
        stale_next = 1'b0;
        if (accept)
        begin
            case (mode)
                MODE_BIT:
                begin
                    if (complete)
                    begin
                        state_next = pick.decided ? rd1[EntW-1:SymW] : rd0[EntW-1:SymW];
                        pos_next   = '0;
                        word_next  = '0;
                        push       = 1'b1;
                    end
                    else
                    begin
                        pos_next  = pos_reg + 3'd1;
                        word_next = word_shift;
                    end
                end
                MODE_LOAD:
                begin
                    stale_next = 1'b1;
                end
                MODE_RESTART:
                begin
                    state_next = '0;
                    pos_next   = '0;
                    word_next  = '0;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    assign pop = m_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg      <= BpsReset;
            state_reg    <= '0;
            pos_reg      <= '0;
            word_reg     <= '0;
            stale_reg    <= 1'b1;
            m_valid_reg  <= 1'b0;
            sk_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                bps_reg <= cfg_wdata;
            end
            state_reg <= state_next;
            pos_reg   <= pos_next;
            word_reg  <= word_next;
            stale_reg <= stale_next;
            if (sk_valid_reg)
            begin
                if (pop)
                begin
                    sk_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (!m_valid_reg || pop)
                begin
                    m_valid_reg <= 1'b1;
                end
                else
                begin
                    sk_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sk_valid_reg)
        begin
            if (pop)
            begin
                m_data_reg <= sk_data_reg;
            end
        end
        else if (push)
        begin
            if (!m_valid_reg || pop)
            begin
                m_data_reg <= result;
            end
            else
            begin
                sk_data_reg <= result;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
